### rtl/core/utf8d_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_pkg
// Shared types, status codes and lead-byte helpers for the UTF-8 decoder.
// ---------------------------------------------------------------------------
package utf8d_pkg;

   localparam int CodeWidth   = 32;
   localparam int CountWidth  = 3;
   localparam int StatusWidth = 2;
   localparam int RspDataWidth = 40;   // 37 field bits padded to whole bytes

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_STRAY   = 2'd1,
      STATUS_BADCONT = 2'd2
   } status_type;

   localparam logic [1:0] ContTag  = 2'b10;
   localparam logic [5:0] ContMask = 6'h3f;

   // decoder state carried from beat to beat
   typedef struct packed {
      logic [CountWidth-1:0] bytes_remaining;
      logic [CountWidth-1:0] sequence_length;
      logic [CodeWidth-1:0]  accumulator;
   } dec_state_type;

   // one result item
   typedef struct packed {
      status_type            status;
      logic [CountWidth-1:0] byte_count;
      logic [CodeWidth-1:0]  code_point;
   } dec_result_type;

   // sequence length from a lead byte, zero for a continuation byte
   function automatic logic [CountWidth-1:0] lead_length(input logic [7:0] b);
      logic [CountWidth-1:0] n;
      unique casez (b)
         8'b0???????: n = 3'd1;
         8'b10??????: n = 3'd0;
         8'b110?????: n = 3'd2;
         8'b1110????: n = 3'd3;
         8'b11110???: n = 3'd4;
         8'b111110??: n = 3'd5;
         8'b1111110?: n = 3'd6;
         default:     n = 3'd7;
      endcase
      return n;
   endfunction

endpackage

### rtl/core/utf8_stream_decoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_core
// Wide-form UTF-8 byte stream decoder, up to seven bytes per character.
// ---------------------------------------------------------------------------
// One byte is taken per beat: the state update (remaining count, length,
// 32-bit accumulator) is combinational and registered on acceptance, and a
// finished character or an error status is held in the result
// register, which is refilled in the same cycle it is drained, so the input
// stalls only while a result waits on a stalled output. Leads and
// continuations that do not end a character produce no result beat.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_core
   import utf8d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata    // [31:0] code_point, [34:32] byte_count,
                                                // [36:35] status, [39:37] zero
);

   dec_state_type  state_ff, state_in;
   dec_state_type  step_nxt;
   dec_result_type step_res;
   logic           step_valid;
   logic           can_load;
   logic           accept;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   utf8d_step u_step (
      .data_byte (req_tdata),
      .state_cur (state_ff),
      .state_nxt (step_nxt),
      .res_valid (step_valid),
      .res       (step_res)
   );

   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   utf8d_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .res_valid  (step_valid),
      .res        (step_res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/utf8d_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_step
// Combinational decode of one byte against the current state: next state
// and the result item, if the byte produces one.
// ---------------------------------------------------------------------------
module utf8d_step
   import utf8d_pkg::*;
(
   input  logic [7:0]     data_byte,
   input  dec_state_type  state_cur,
   output dec_state_type  state_nxt,
   output logic           res_valid,
   output dec_result_type res
);

   logic [CountWidth-1:0] lead_n;
   logic [7:0]            lead_bits;
   logic [CodeWidth-1:0]  acc_shift;
   logic                  is_cont;

   assign lead_n    = lead_length(data_byte);
   assign lead_bits = data_byte & (8'hff >> lead_n);
   assign acc_shift = {state_cur.accumulator[CodeWidth-7:0], data_byte[5:0] & ContMask};
   assign is_cont   = (data_byte[7:6] == ContTag);

   always_comb begin
      state_nxt      = state_cur;
      res_valid      = 1'b0;
      res.status     = STATUS_OK;
      res.byte_count = '0;
      res.code_point = '0;
      if (state_cur.bytes_remaining == '0) begin
         if (lead_n == '0) begin
            res_valid  = 1'b1;
            res.status = STATUS_STRAY;
         end else if (lead_n == 3'd1) begin
            state_nxt.accumulator     = {24'd0, lead_bits};
            state_nxt.sequence_length = '0;
            res_valid      = 1'b1;
            res.byte_count = 3'd1;
            res.code_point = {24'd0, lead_bits};
         end else begin
            state_nxt.accumulator     = {24'd0, lead_bits};
            state_nxt.sequence_length = lead_n;
            state_nxt.bytes_remaining = lead_n - 3'd1;
         end
      end else if (!is_cont) begin
         // partial sequence dropped along with the offending byte
         state_nxt  = '0;
         res_valid  = 1'b1;
         res.status = STATUS_BADCONT;
      end else begin
         state_nxt.accumulator     = acc_shift;
         state_nxt.bytes_remaining = state_cur.bytes_remaining - 3'd1;
         if (state_cur.bytes_remaining == 3'd1) begin
            state_nxt.sequence_length = '0;
            res_valid      = 1'b1;
            res.byte_count = state_cur.sequence_length;
            res.code_point = acc_shift;
         end
      end
   end

endmodule

### rtl/core/utf8d_out_reg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_out_reg
// Result register of the decoder; refills in the same cycle it drains.
// ---------------------------------------------------------------------------
module utf8d_out_reg
   import utf8d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    res_valid,
   input  dec_result_type          res,
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic           valid_ff, valid_in;
   dec_result_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = res_valid;
         data_in  = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(dec_result_type)){1'b0}}, data_ff};

endmodule

### rtl/core/utf8d_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result stream.
// ---------------------------------------------------------------------------
module utf8d_checker
   import utf8d_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // error beats carry no character
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[36:35] != STATUS_OK) |-> rsp_tdata[34:0] == '0)
      else $error("error beat with nonzero code point or count");

   // good beats have a length and valid status code
   a_ok_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[36:35] == STATUS_STRAY || rsp_tdata[36:35] == STATUS_BADCONT
                      || (rsp_tdata[36:35] == STATUS_OK && rsp_tdata[34:32] != '0)))
      else $error("bad status or zero length on ok beat");

   // no result appears without a byte taken in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid ##1 rsp_tvalid |-> $past(req_tvalid && req_tready))
      else $error("result beat without an accepted byte");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### sim/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_decode_checker
// Watches both streams of the UTF-8 decoder, predicts each character or error
// beat from the accepted input bytes and compares every result field.
// ---------------------------------------------------------------------------
module utf8_decode_checker
   import utf8d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,
   output int                      mismatch_count,
   output int                      pending_results
);

   localparam int FieldBits = CodeWidth + CountWidth + StatusWidth;

   // own copy of the decoder state
   logic [CountWidth-1:0] bytes_left;
   logic [CountWidth-1:0] char_len;
   logic [CodeWidth-1:0]  partial_code;

   dec_result_type expected_chars[$];

   function automatic int leading_ones(input logic [7:0] b);
      int k;
      k = 0;
      while (k < 8 && b[7-k]) k++;
      return k;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_result(input status_type st, input logic [CountWidth-1:0] cnt,
                               input logic [CodeWidth-1:0] cp);
      dec_result_type r;
      r.status     = st;
      r.byte_count = cnt;
      r.code_point = cp;
      expected_chars.push_back(r);
   endtask

   task automatic predict_byte(input logic [7:0] b);
      int                    ones;
      logic [CountWidth-1:0] n;
      if (bytes_left == 0) begin
         ones = leading_ones(b);
         if (ones == 1) begin
            // stray continuation, byte dropped
            queue_result(STATUS_STRAY, '0, '0);
         end else begin
            n = (ones == 0) ? 3'd1 : (ones >= 7) ? 3'd7 : ones[CountWidth-1:0];
            partial_code = 32'(b & (8'hff >> n));
            if (n == 1) begin
               char_len = '0;
               queue_result(STATUS_OK, 3'd1, partial_code);
            end else begin
               char_len   = n;
               bytes_left = n - 3'd1;
            end
         end
      end else if (b[7:6] != ContTag) begin
         // bad byte inside a sequence: drop it and the partial character
         bytes_left   = '0;
         char_len     = '0;
         partial_code = '0;
         queue_result(STATUS_BADCONT, '0, '0);
      end else begin
         partial_code = {partial_code[CodeWidth-7:0], b[5:0]};
         bytes_left   = bytes_left - 3'd1;
         if (bytes_left == 0) begin
            queue_result(STATUS_OK, char_len, partial_code);
            char_len = '0;
         end
      end
   endtask

   task automatic check_result(input logic [RspDataWidth-1:0] beat);
      dec_result_type got;
      dec_result_type want;
      got = beat[FieldBits-1:0];
      if (expected_chars.size() == 0) begin
         report_mismatch("unexpected result beat", 32'(beat[FieldBits-1:0]), '0);
      end else begin
         want = expected_chars.pop_front();
         if (got.code_point !== want.code_point)
            report_mismatch("code_point", got.code_point, want.code_point);
         if (got.byte_count !== want.byte_count)
            report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      if (beat[RspDataWidth-1:FieldBits] !== '0)
         report_mismatch("padding", 32'(beat[RspDataWidth-1:FieldBits]), '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bytes_left      = '0;
         char_len        = '0;
         partial_code    = '0;
         expected_chars.delete();
         mismatch_count  = 0;
         pending_results = 0;
      end else begin
         // results at this edge come from earlier bytes, so check first
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (req_tvalid && req_tready) predict_byte(req_tdata);
         pending_results = expected_chars.size();
      end
   end

endmodule

### sim/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Drives byte streams into the UTF-8 decoder: a directed set of edge cases,
// then mostly well-formed random characters mixed with noise and truncated
// sequences, with random stalls on both streams and a long output hold-off.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;
   import utf8d_pkg::*;

   localparam int RandomBytes = 1250;
   localparam int QuietTail   = 150;
   localparam int HoldCycles  = 300;
   localparam int HoldAt      = 300;
   localparam int DrainAt     = 700;
   localparam int CycleLimit  = 200000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   int mismatch_count;
   int pending_results;
   int bytes_sent = 0;
   int byte_target = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;
   bit long_hold_req = 1'b0;

   always #2 clock = ~clock;

   utf8_stream_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   utf8_decode_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // lead byte of a len-byte sequence, free bits from fill
   function automatic logic [7:0] lead_byte(input int len, input logic [7:0] fill);
      if (len == 1) return {1'b0, fill[6:0]};
      if (len == 7) return {7'h7f, fill[0]};
      return (8'hff << (8 - len)) | (fill & (8'hff >> (len + 1)));
   endfunction

   function automatic logic [7:0] cont_byte();
      return {ContTag, 6'($urandom_range(0, 63))};
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      quiet = (bytes_sent >= byte_target - QuietTail);
   endtask

   task automatic send_random_char();
      int         kind;
      int         len;
      int         conts;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 7);
      if (kind < 88) begin
         send_byte(lead_byte(len, 8'($urandom_range(0, 255))));
         repeat (len - 1) send_byte(cont_byte());
      end else if (kind < 94) begin
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         // truncated sequence ended by a byte that is no continuation
         if (len == 1) len = 2;
         conts = $urandom_range(0, len - 2);
         send_byte(lead_byte(len, 8'($urandom_range(0, 255))));
         repeat (conts) send_byte(cont_byte());
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == ContTag) b[6] = 1'b1;
         send_byte(b);
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      bit         held;
      bit         drained;
      held    = 1'b0;
      drained = 1'b0;
      directed = '{8'h00, 8'h80,                              // ascii low, stray
                   8'hdf, 8'hbf,                              // two byte max
                   8'he0, 8'h80, 8'h80,                       // overlong three byte
                   8'hf4, 8'h8f, 8'hbf, 8'hbf,
                   8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
                   8'hfe, 8'h83, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,  // seven byte overflow
                   8'hc2, 8'hc3,                              // bad byte that looks like a lead
                   8'h7f};
      byte_target = directed.size() + RandomBytes;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_byte(directed[i]);
      while (bytes_sent < byte_target) begin
         if (!held && bytes_sent >= HoldAt) begin
            held          = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!drained && bytes_sent >= DrainAt) begin
            // let every pending result out before going on
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_results != 0) @(posedge clock);
         end
         send_random_char();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
